// ===== sv/arp_cache_table_with_aging_top_macros.svh =====
// Assertion macros for the ARP cache table.
// Expects i_clk and i_rst_n in the module that uses them.
`ifndef ARP_CACHE_TABLE_WITH_AGING_TOP_MACROS_SVH
`define ARP_CACHE_TABLE_WITH_AGING_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ARPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arpc: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define ARPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arpc: next-cycle check failed");

`endif

// ===== sv/arpc_pkg.sv =====
// Shared types and constants for the ARP cache table.
// No dependencies.
`timescale 1ns / 1ps

package arpc_pkg;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [7:0] AGE_MAX       = 8'd255;
    localparam logic [7:0] TIMEOUT_RESET = 8'd15;
    localparam int         SLOT_W        = 7;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac_found;
        logic        stored;
        logic [6:0]  slot;
    } t_out_item;

    // One table entry as held in the RAM.
    typedef struct packed {
        logic        valid;
        logic [7:0]  age;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // latch accepted item, clear scan trackers
        logic clr_we;    // reset clearing pass write
        logic rd_en;     // scan read at the given address
        logic out_load;  // finish: load result, do the insert write
    } t_cmd;

endpackage

// ===== sv/arp_cache_table_with_aging_top.sv =====
// Top level of the ARP cache table with aging.
// Depends on arpc_pkg, arpc_ctrl, arpc_dp (and arpc_ram below it).
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_stall  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (timeout_seconds)
//
// Every item scans all ENTRIES slots through the one read port of the entry RAM.
// After the accept the controller runs the scan, tail and done states; done
// loads the result register, and waits while the output holds a stalled result.
// No new item is taken before that load. After reset a clearing pass writes every
// slot, during which no item is taken. The next item is taken while a result waits
// in the output register. The configuration port is always ready.
`timescale 1ns / 1ps

module arp_cache_table_with_aging_top #(
    parameter int ENTRIES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arpc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpc_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cmd             cmd;
    logic [IDX_W-1:0] addr;

    assign o_cfg_ready = 1'b1;

    arpc_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_addr     (addr),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

// ===== sv/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/arpc_ctrl.sv =====
// Controller for the ARP cache table: clearing pass, scan sequencing, output valid.
// Depends on arpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "arp_cache_table_with_aging_top_macros.svh"

module arpc_ctrl #(
    parameter int ENTRIES = 128,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output arpc_pkg::t_cmd     o_cmd,
    output logic [IDX_W-1:0]   o_addr
);

    import arpc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        cmd     = '0;
        case (r_state)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = IDX_W'(r_addr + 1'b1);
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SCAN;
                    n_addr   = '0;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (r_addr == LAST) begin
                    n_state = ST_TAIL;
                    n_addr  = '0;
                end else begin
                    n_addr = IDX_W'(r_addr + 1'b1);
                end
            end
            ST_TAIL: begin
                // last read word is handled in the datapath this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_addr      = r_addr;

    `ARPC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !r_out_valid || !i_out_stall)
    `ARPC_ASSERT_NXT(a_accept_scan, i_in_valid && !o_in_stall, r_state == ST_SCAN && r_addr == '0)
    `ARPC_ASSERT_NXT(a_tail_done, r_state == ST_TAIL, r_state == ST_DONE)
    `ARPC_ASSERT_NXT(a_scan_end, r_state == ST_SCAN && r_addr == LAST, r_state == ST_TAIL)

endmodule

// ===== sv/arpc_dp.sv =====
// Datapath for the ARP cache table: entry RAM, scan trackers, tick write-back,
// timeout register and result register. Depends on arpc_pkg and arpc_ram.
`timescale 1ns / 1ps

module arpc_dp #(
    parameter int ENTRIES = 128,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_cmd      i_cmd,
    input  logic [IDX_W-1:0]    i_addr,
    input  arpc_pkg::t_in_item  i_in_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    output arpc_pkg::t_out_item o_out_item
);

    import arpc_pkg::*;

    localparam int EW = $bits(t_entry);

    logic [7:0]       r_timeout;
    logic [1:0]       r_func;
    logic [31:0]      r_ip;
    logic [47:0]      r_mac;
    logic             r_dv;
    logic [IDX_W-1:0] r_didx;
    logic             r_hit;
    logic [47:0]      r_mac_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    t_out_item        r_out;

    t_entry           rd_entry;
    logic [EW-1:0]    rd_word;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic             tick_we;
    logic [7:0]       aged;
    logic             match;
    logic             ins_we;
    logic [IDX_W+SLOT_W-1:0] hit_ext;
    logic [IDX_W+SLOT_W-1:0] free_ext;
    t_out_item        res;

    arpc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_addr),
        .o_rdata (rd_word)
    );

    assign rd_entry = t_entry'(rd_word);
    assign aged     = (rd_entry.age == AGE_MAX) ? rd_entry.age : rd_entry.age + 8'd1;
    assign match    = rd_entry.valid && (rd_entry.ip == r_ip);
    assign tick_we  = r_dv && (r_func == FUNC_TICK) && rd_entry.valid;
    assign ins_we   = i_cmd.out_load && (r_func == FUNC_INSERT) && r_free_found;

    // one writer at a time: clearing pass, tick write-back, or insert
    always_comb begin
        we    = i_cmd.clr_we || tick_we || ins_we;
        waddr = i_addr;
        wdata = '0;
        if (tick_we) begin
            waddr       = r_didx;
            wdata       = rd_entry;
            wdata.age   = aged;
            wdata.valid = (aged <= r_timeout);
        end else if (ins_we) begin
            waddr       = r_free_idx;
            wdata.valid = 1'b1;
            wdata.age   = 8'd0;
            wdata.ip    = r_ip;
            wdata.mac   = r_mac;
        end
    end

    assign hit_ext  = {{SLOT_W{1'b0}}, r_hit_idx};
    assign free_ext = {{SLOT_W{1'b0}}, r_free_idx};

    always_comb begin
        res = '0;
        case (r_func)
            FUNC_LOOKUP: begin
                res.hit       = r_hit;
                res.mac_found = r_mac_found;
                res.slot      = r_hit ? hit_ext[SLOT_W-1:0] : '0;
            end
            FUNC_INSERT: begin
                res.stored = r_free_found;
                res.slot   = r_free_found ? free_ext[SLOT_W-1:0] : '0;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_dv      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            r_dv <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= i_addr;
        if (i_cmd.load) begin
            r_func       <= i_in_item.func;
            r_ip         <= i_in_item.ip_addr;
            r_mac        <= i_in_item.mac_addr;
            r_hit        <= 1'b0;
            r_mac_found  <= '0;
            r_hit_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else if (r_dv) begin
            // later matches win: highest index
            if (r_func == FUNC_LOOKUP && match) begin
                r_hit       <= 1'b1;
                r_mac_found <= rd_entry.mac;
                r_hit_idx   <= r_didx;
            end
            // first free slot wins: lowest index
            if (r_func == FUNC_INSERT && !rd_entry.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_didx;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== sim/arpc_checker.sv =====
// Checker for the ARP cache table: watches the in, out and config channels.
// Keeps its own copy of the table, predicts each result and compares it.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_checker #(
    parameter int ENTRIES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  arpc_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  arpc_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);
    import arpc_pkg::*;

    bit          tbl_valid [ENTRIES];
    logic [31:0] tbl_ip    [ENTRIES];
    logic [47:0] tbl_mac   [ENTRIES];
    logic [7:0]  tbl_age   [ENTRIES];
    logic [7:0]  timeout_s = TIMEOUT_RESET;

    t_out_item   answers_q[$];

    task automatic flag_mismatch(input string note);
        o_errors++;
        if (o_errors <= 40) begin
            $display("%0t: %s", $realtime, note);
        end
    endtask

    // Applies one operation to the table copy and returns its result.
    function automatic t_out_item arp_table_step(input t_in_item it);
        t_out_item r;
        int        k;
        r = '0;
        case (it.func)
            FUNC_LOOKUP: begin
                for (k = 0; k < ENTRIES; k++) begin
                    if (tbl_valid[k] && tbl_ip[k] == it.ip_addr) begin
                        r.hit       = 1'b1;
                        r.mac_found = tbl_mac[k];
                        r.slot      = k[SLOT_W-1:0];
                    end
                end
            end
            FUNC_INSERT: begin
                k = 0;
                while (k < ENTRIES && tbl_valid[k]) k++;
                if (k < ENTRIES) begin
                    tbl_ip[k]    = it.ip_addr;
                    tbl_mac[k]   = it.mac_addr;
                    tbl_age[k]   = '0;
                    tbl_valid[k] = 1'b1;
                    r.stored     = 1'b1;
                    r.slot       = k[SLOT_W-1:0];
                end
            end
            FUNC_TICK: begin
                for (k = 0; k < ENTRIES; k++) begin
                    if (tbl_valid[k]) begin
                        if (tbl_age[k] < AGE_MAX) tbl_age[k] = tbl_age[k] + 8'd1;
                        if (tbl_age[k] > timeout_s) tbl_valid[k] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tbl_valid = '{default: 1'b0};
            timeout_s = TIMEOUT_RESET;
            answers_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) timeout_s = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (answers_q.size() == 0) begin
                    flag_mismatch("result item with nothing expected");
                end else begin
                    want = answers_q.pop_front();
                    if (i_out_item.hit !== want.hit)
                        flag_mismatch($sformatf("hit: got %0h expected %0h",
                                                i_out_item.hit, want.hit));
                    if (i_out_item.mac_found !== want.mac_found)
                        flag_mismatch($sformatf("mac_found: got %0h expected %0h",
                                                i_out_item.mac_found, want.mac_found));
                    if (i_out_item.stored !== want.stored)
                        flag_mismatch($sformatf("stored: got %0h expected %0h",
                                                i_out_item.stored, want.stored));
                    if (i_out_item.slot !== want.slot)
                        flag_mismatch($sformatf("slot: got %0d expected %0d",
                                                i_out_item.slot, want.slot));
                end
            end
            if (i_in_valid && !i_in_stall) answers_q.push_back(arp_table_step(i_in_item));
        end
        o_pending <= answers_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for arp_cache_table_with_aging_top: clock, reset, stimulus, verdict.
// Depends on arpc_pkg, the block's RTL and arpc_checker.
`timescale 1ns / 1ps

module tb;
    import arpc_pkg::*;

    localparam int         ENTRIES    = 128;
    localparam int         LIMIT      = 1_500_000;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [7:0] cfg_data = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      o_cfg_ready;
    int        pending;
    int        errors;
    int        cycles = 0;

    // sender state
    bit          drive_on = 1'b0;
    int          burst_left = 0;
    logic [31:0] ip_pool [16];

    // receiver stall pattern
    int stall_mode = 0;
    int mode_left = 0;
    int run_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    arp_cache_table_with_aging_top #(.ENTRIES(ENTRIES)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    arpc_checker #(.ENTRIES(ENTRIES)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("arp_cache_table_with_aging_top test failed");
            $finish;
        end
    end

    // Stall modes: free, light random, long runs that back up the block.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            mode_left  <= $urandom_range(400, 100);
            stall_mode <= $urandom_range(2, 0);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3, 0) == 0);
            default: begin
                if (run_left == 0) begin
                    out_stall <= ~out_stall;
                    run_left  <= out_stall ? $urandom_range(20, 1) : $urandom_range(150, 1);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    function automatic t_in_item mk(input logic [1:0] f, input logic [31:0] ip,
                                    input logic [47:0] mac);
        t_in_item it;
        it.func     = f;
        it.ip_addr  = ip;
        it.mac_addr = mac;
        return it;
    endfunction

    // Lookups and inserts mostly reuse a small address pool so lookups hit.
    function automatic t_in_item rand_item(input int pct_lookup, input int pct_insert);
        t_in_item it;
        int       roll;
        bit       fresh;
        roll        = $urandom_range(99, 0);
        fresh       = ($urandom_range(3, 0) == 0);
        it.ip_addr  = fresh ? $urandom : ip_pool[$urandom_range(15, 0)];
        it.mac_addr = 48'({$urandom, $urandom});
        if (roll < pct_lookup) begin
            it.func = FUNC_LOOKUP;
        end else if (roll < pct_lookup + pct_insert) begin
            it.func = FUNC_INSERT;
            if (fresh) ip_pool[$urandom_range(15, 0)] = it.ip_addr;
        end else if (roll < 98) begin
            it.func = FUNC_TICK;
        end else begin
            it.func = FUNC_RSVD;
        end
        return it;
    endfunction

    task automatic stop_driving;
        if (drive_on) begin
            in_valid <= 1'b0;
            drive_on = 1'b0;
        end
    endtask

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            stop_driving();
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(130, 1) : $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(8, 1);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        drive_on = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Holds the sender until every expected result has come back.
    task automatic wait_idle;
        stop_driving();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int count, input int pct_lookup, input int pct_insert);
        t_in_item it;
        int       done;
        done = 0;
        while (done < count) begin
            it = rand_item(pct_lookup, pct_insert);
            send_item(it);
            if (it.func != FUNC_RSVD) done++;
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < 16; i++) ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hffff_ffff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, unused code, tick
        send_item(mk(FUNC_LOOKUP, 32'h0, 48'h0));
        send_item(mk(FUNC_INSERT, 32'h0, 48'h0));
        send_item(mk(FUNC_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff));
        send_item(mk(FUNC_INSERT, 32'hffff_ffff, 48'h1234_5678_9abc));
        send_item(mk(FUNC_LOOKUP, 32'hffff_ffff, 48'h0));
        send_item(mk(FUNC_LOOKUP, 32'h0, 48'hffff_ffff_ffff));
        send_item(mk(FUNC_RSVD, 32'hffff_ffff, 48'hffff_ffff_ffff));
        send_item(mk(FUNC_TICK, 32'hffff_ffff, 48'hffff_ffff_ffff));
        send_item(mk(FUNC_LOOKUP, 32'h0a00_0001, 48'h0));
        // zero timeout: next tick drops everything
        cfg_write(8'd0);
        send_item(mk(FUNC_TICK, 32'h0, 48'h0));
        send_item(mk(FUNC_LOOKUP, 32'hffff_ffff, 48'h0));
        // timeout 1: survives one tick, gone after the second
        cfg_write(8'd1);
        send_item(mk(FUNC_INSERT, 32'hc0a8_0001, 48'h0000_0000_0001));
        send_item(mk(FUNC_TICK, 32'h0, 48'h0));
        send_item(mk(FUNC_LOOKUP, 32'hc0a8_0001, 48'h0));
        send_item(mk(FUNC_TICK, 32'h0, 48'h0));
        send_item(mk(FUNC_LOOKUP, 32'hc0a8_0001, 48'h0));

        // max timeout: fill past capacity, then age until saturation
        cfg_write(8'd255);
        for (i = 0; i < 180; i++) begin
            send_item((i % 4 == 3) ? rand_item(100, 0) : rand_item(0, 100));
        end
        for (i = 0; i < 290; i++) begin
            if (i % 10 == 9) send_item(rand_item(100, 0));
            else send_item(mk(FUNC_TICK, $urandom, 48'({$urandom, $urandom})));
        end

        // short timeout clears the saturated table
        cfg_write(8'd2);
        run_mix(200, 45, 35);

        cfg_write(8'($urandom_range(254, 2)));
        run_mix(100, 45, 35);
        wait_idle();
        run_mix(100, 45, 35);

        cfg_write(8'd1);
        run_mix(150, 40, 40);

        cfg_write(TIMEOUT_RESET);
        run_mix(130, 45, 35);

        wait_idle();
        repeat (140) @(posedge i_clk);
        if (errors == 0) begin
            $display("arp_cache_table_with_aging_top test passed");
        end else begin
            $display("arp_cache_table_with_aging_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arpc_ctrl.sv
sv/arpc_dp.sv
sv/arp_cache_table_with_aging_top.sv
sim/arpc_checker.sv
sim/tb.sv
